@@ hw/rtl/n2a_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// n2a_pkg
// Shared types, format codes and ASCII helpers for the number formatter.
// ----------------------------------------------------------------------------
package n2a_pkg;

    localparam logic [1:0] OP_DEC    = 2'd0;
    localparam logic [1:0] OP_HEX_LO = 2'd1;
    localparam logic [1:0] OP_HEX_UP = 2'd2;
    localparam logic [1:0] OP_PTR    = 2'd3;

    localparam logic [7:0] ASCII_ZERO = 8'd48;
    localparam logic [7:0] ASCII_X    = 8'd120;
    localparam logic [7:0] ASCII_UP   = 8'd55;
    localparam logic [7:0] ASCII_LO   = 8'd87;

    typedef struct packed {
        logic [63:0] value;
        logic [1:0]  operation;
    } t_in;

    typedef struct packed {
        logic [7:0] character;
        logic       last_char;
    } t_out;

    typedef struct packed {
        logic load;
        logic upper;
        logic prefix;
    } t_emit_ctl;

    function automatic logic [7:0] f_digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] base;
        if (d < 4'd10) begin
            base = ASCII_ZERO;
        end else if (upper) begin
            base = ASCII_UP;
        end else begin
            base = ASCII_LO;
        end
        return base + {4'h0, d};
    endfunction

endpackage

@@ hw/rtl/n2a_bcd.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// n2a_bcd
// Bit-serial binary to BCD converter (shift and add-three), one bit a cycle.
// ----------------------------------------------------------------------------
module n2a_bcd #(
    parameter int DEC_WIDTH  = 32,
    parameter int DEC_DIGITS = 10
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [DEC_WIDTH-1:0]      i_bin,
    output logic                      o_done,
    output logic [DEC_DIGITS*4-1:0]   o_bcd
);

    localparam int CW = $clog2(DEC_WIDTH + 1);
    localparam int BW = DEC_DIGITS * 4;

    logic [DEC_WIDTH-1:0] r_bin;
    logic [BW-1:0]        r_bcd;
    logic [CW-1:0]        r_cnt;
    logic                 r_done;
    logic [BW-1:0]        n_bcd;

    // add three to every digit of five or more, then shift in the next bit
    always_comb begin
        logic [BW-1:0] adj;
        adj = r_bcd;
        for (int k = 0; k < DEC_DIGITS; k++) begin
            if (r_bcd[k*4 +: 4] >= 4'd5) begin
                adj[k*4 +: 4] = r_bcd[k*4 +: 4] + 4'd3;
            end
        end
        n_bcd = {adj[BW-2:0], r_bin[DEC_WIDTH-1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_bin <= i_bin;
                r_bcd <= '0;
                r_cnt <= CW'(DEC_WIDTH);
            end else if (r_cnt != '0) begin
                r_bin  <= {r_bin[DEC_WIDTH-2:0], 1'b0};
                r_bcd  <= n_bcd;
                r_cnt  <= r_cnt - CW'(1);
                r_done <= (r_cnt == CW'(1));
            end
        end
    end

    assign o_done = r_done;
    assign o_bcd  = r_bcd;

endmodule

@@ hw/rtl/n2a_emit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// n2a_emit
// Digit shift line: drops leading zeros, sends one character per beat.
// ----------------------------------------------------------------------------
module n2a_emit #(
    parameter int NDIG = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  n2a_pkg::t_emit_ctl   i_ctl,
    input  logic [NDIG*4-1:0]    i_digits,
    output logic                 o_idle,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output n2a_pkg::t_out        o_out
);

    localparam int LW = NDIG * 4;
    localparam int CW = $clog2(NDIG + 1);

    typedef enum logic [2:0] {
        E_IDLE,
        E_PRE0,
        E_PREX,
        E_SKIP,
        E_DIG
    } t_state;

    t_state          r_state;
    logic [LW-1:0]   r_line;
    logic [CW-1:0]   r_left;
    logic            r_upper;
    logic            r_valid;
    n2a_pkg::t_out   r_out;
    logic            w_free;
    logic            w_emit;
    logic [3:0]      w_top;

    assign w_free = !r_valid || i_out_ready;
    assign w_top  = r_line[LW-1 -: 4];
    assign w_emit = w_free &&
                    (r_state == E_PRE0 || r_state == E_PREX || r_state == E_DIG);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= E_IDLE;
            r_valid <= 1'b0;
        end else begin
            if (w_emit) begin
                r_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_valid <= 1'b0;
            end
            unique case (r_state)
                E_IDLE: begin
                    if (i_ctl.load) begin
                        r_line  <= i_digits;
                        r_left  <= CW'(NDIG);
                        r_upper <= i_ctl.upper;
                        r_state <= i_ctl.prefix ? E_PRE0 : E_SKIP;
                    end
                end
                E_PRE0: begin
                    if (w_free) begin
                        r_out.character <= n2a_pkg::ASCII_ZERO;
                        r_out.last_char <= 1'b0;
                        r_state         <= E_PREX;
                    end
                end
                E_PREX: begin
                    if (w_free) begin
                        r_out.character <= n2a_pkg::ASCII_X;
                        r_out.last_char <= 1'b0;
                        r_state         <= E_SKIP;
                    end
                end
                E_SKIP: begin
                    if (w_top == 4'h0 && r_left != CW'(1)) begin
                        r_line <= {r_line[LW-5:0], 4'h0};
                        r_left <= r_left - CW'(1);
                    end else begin
                        r_state <= E_DIG;
                    end
                end
                E_DIG: begin
                    if (w_free) begin
                        r_out.character <= n2a_pkg::f_digit_char(w_top, r_upper);
                        r_out.last_char <= (r_left == CW'(1));
                        r_line          <= {r_line[LW-5:0], 4'h0};
                        r_left          <= r_left - CW'(1);
                        if (r_left == CW'(1)) begin
                            r_state <= E_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= E_IDLE;
                end
            endcase
        end
    end

    assign o_idle      = (r_state == E_IDLE);
    assign o_out_valid = r_valid;
    assign o_out       = r_out;

endmodule

@@ hw/rtl/number_to_ascii_formatter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// number_to_ascii_formatter
// Formats an unsigned value as decimal, hex or 0x-prefixed pointer ASCII.
//
//   channel | direction | payload                    | handshake
//   in      | input     | value, operation (t_in)    | i_in_valid / o_in_ready
//   out     | output    | character, last_char       | o_out_valid / i_out_ready
//
// hex and pointer items: the accept edge loads the digit line; pointer items
// then send the 0 and x prefix characters, leading zero digits are dropped,
// the skip state hands over to the digit state, then the characters follow.
// decimal items first pass through the bit-serial BCD converter.
// one item is in work at a time; the next is taken once the last character
// sits in the output register. output stalls hold the digit line while characters are sent.
// reset is synchronous; it clears all control state.
// ----------------------------------------------------------------------------
module number_to_ascii_formatter #(
    parameter int HEX_WIDTH = 64,
    parameter int DEC_WIDTH = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  n2a_pkg::t_in    i_in,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output n2a_pkg::t_out   o_out
);

    localparam int HEX_DIGITS = (HEX_WIDTH + 3) / 4;
    localparam int DEC_DIGITS = (DEC_WIDTH * 30103) / 100000 + 1;
    localparam int NDIG       = (HEX_DIGITS > DEC_DIGITS) ? HEX_DIGITS : DEC_DIGITS;
    localparam int LW         = NDIG * 4;

    typedef enum logic {
        S_IDLE,
        S_CONV
    } t_state;

    t_state                 r_state;
    logic                   w_accept;
    logic                   w_is_dec;
    logic                   w_emit_idle;
    logic                   w_bcd_done;
    logic [DEC_DIGITS*4-1:0] w_bcd;
    logic [LW-1:0]          w_digits;
    n2a_pkg::t_emit_ctl     w_ctl;

    assign o_in_ready = (r_state == S_IDLE) && w_emit_idle;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_is_dec   = (i_in.operation == n2a_pkg::OP_DEC);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept && w_is_dec) begin
                        r_state <= S_CONV;
                    end
                end
                S_CONV: begin
                    if (w_bcd_done) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign w_ctl = '{
        load:   (w_accept && !w_is_dec) || w_bcd_done,
        upper:  w_accept && (i_in.operation == n2a_pkg::OP_HEX_UP),
        prefix: w_accept && (i_in.operation == n2a_pkg::OP_PTR)
    };
    assign w_digits     = (r_state == S_CONV) ? LW'(w_bcd) : LW'(i_in.value[HEX_WIDTH-1:0]);

    n2a_bcd #(
        .DEC_WIDTH  (DEC_WIDTH),
        .DEC_DIGITS (DEC_DIGITS)
    ) u_bcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept && w_is_dec),
        .i_bin   (i_in.value[DEC_WIDTH-1:0]),
        .o_done  (w_bcd_done),
        .o_bcd   (w_bcd)
    );

    n2a_emit #(
        .NDIG (NDIG)
    ) u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_ctl),
        .i_digits    (w_digits),
        .o_idle      (w_emit_idle),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    a_hex_starts_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !w_is_dec) |=> !w_emit_idle)
        else $error("hex beat did not start the emitter");

    a_done_in_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_bcd_done |-> (r_state == S_CONV) && w_emit_idle)
        else $error("bcd done outside conversion");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_in_ready)
        else $error("second beat taken while busy");

endmodule

@@ dv/number_to_ascii_formatter_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// number_to_ascii_formatter_test
// Self-checking bench for the number formatter. A short table of directed
// numbers covers zero, the field extremes, ignored upper bits and every
// format. 340 random numbers follow, with varied digit counts, under
// four idle/stall mixes and one long output hold-off. Every output beat
// is compared with a character queue from the table or an in-bench formatter.
// ----------------------------------------------------------------------------
module number_to_ascii_formatter_test;

    localparam int HEX_BITS       = 64;
    localparam int DEC_BITS       = 32;
    localparam int ITEMS_PER_MIX  = 85;
    localparam int HOLD_OFF_LEN   = 500;
    localparam int DRAIN_CYCLES   = 80;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int N_DIRECTED     = 22;
    localparam logic [159:0] BY_FORMATTER = '0;

    typedef struct packed {
        n2a_pkg::t_in stim;
        logic [159:0] text;
    } t_directed_row;

    localparam t_directed_row DIRECTED_ROWS [N_DIRECTED] = '{
        '{'{64'd0, n2a_pkg::OP_DEC}, "0"},
        '{'{64'd0, n2a_pkg::OP_HEX_LO}, "0"},
        '{'{64'd0, n2a_pkg::OP_HEX_UP}, "0"},
        '{'{64'd0, n2a_pkg::OP_PTR}, "0x0"},
        '{'{64'h0000_0000_FFFF_FFFF, n2a_pkg::OP_DEC}, "4294967295"},
        '{'{64'hFFFF_FFFF_FFFF_FFFF, n2a_pkg::OP_DEC}, "4294967295"},
        '{'{64'hFFFF_FFFF_FFFF_FFFF, n2a_pkg::OP_HEX_LO}, "ffffffffffffffff"},
        '{'{64'hFFFF_FFFF_FFFF_FFFF, n2a_pkg::OP_HEX_UP}, "FFFFFFFFFFFFFFFF"},
        '{'{64'hFFFF_FFFF_FFFF_FFFF, n2a_pkg::OP_PTR}, "0xffffffffffffffff"},
        '{'{64'h0000_0001_0000_0000, n2a_pkg::OP_DEC}, "0"},
        '{'{64'h8000_0000_0000_0000, n2a_pkg::OP_DEC}, "0"},
        '{'{64'd1, n2a_pkg::OP_DEC}, "1"},
        '{'{64'd9, n2a_pkg::OP_DEC}, "9"},
        '{'{64'd10, n2a_pkg::OP_DEC}, "10"},
        '{'{64'h8000_0000_0000_0000, n2a_pkg::OP_HEX_UP}, "8000000000000000"},
        '{'{64'h0123_4567_89AB_CDEF, n2a_pkg::OP_HEX_LO}, "123456789abcdef"},
        '{'{64'h0123_4567_89AB_CDEF, n2a_pkg::OP_HEX_UP}, "123456789ABCDEF"},
        '{'{64'hF, n2a_pkg::OP_PTR}, "0xf"},
        '{'{64'hA, n2a_pkg::OP_HEX_UP}, "A"},
        '{'{64'hFEDC_BA98_7654_3210, n2a_pkg::OP_PTR}, BY_FORMATTER},
        '{'{64'h5555_5555_3B9A_CA00, n2a_pkg::OP_DEC}, BY_FORMATTER},
        '{'{64'hAAAA_AAAA_AAAA_AAAA, n2a_pkg::OP_HEX_LO}, BY_FORMATTER}
    };

    logic          i_clk;
    logic          i_rst_n     = 1'b0;
    logic          in_valid    = 1'b0;
    logic          in_ready;
    n2a_pkg::t_in  in_beat     = '0;
    logic          out_valid;
    logic          out_ready   = 1'b0;
    n2a_pkg::t_out out_beat;

    n2a_pkg::t_out pending_chars [$];
    n2a_pkg::t_out expected_char;
    int   mismatch_count = 0;
    int   tx_idle_pct    = 0;
    int   rx_stall_pct   = 0;
    int   hold_off_req   = 0;
    int   hold_off_done  = 0;
    int   hold_left      = 0;
    int   quiet_cycles   = 0;

    number_to_ascii_formatter #(
        .HEX_WIDTH (HEX_BITS),
        .DEC_WIDTH (DEC_BITS)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_beat),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_beat)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // queue the characters of one number, most significant first
    function automatic void predict_chars(input n2a_pkg::t_in item);
        logic [7:0]  digits [$];
        logic [63:0] rest;
        logic [3:0]  nib;
        int          n;
        if (item.operation == n2a_pkg::OP_DEC) begin
            rest = item.value & ((64'd1 << DEC_BITS) - 64'd1);
            do begin
                digits.push_back(8'h30 + 8'(rest % 64'd10));
                rest = rest / 64'd10;
            end while (rest != 64'd0);
        end else begin
            rest = item.value &
                   ((HEX_BITS >= 64) ? ~64'd0 : ((64'd1 << HEX_BITS) - 64'd1));
            do begin
                nib = rest[3:0];
                if (nib < 4'd10) begin
                    digits.push_back(8'h30 + {4'h0, nib});
                end else if (item.operation == n2a_pkg::OP_HEX_UP) begin
                    digits.push_back(8'h41 + {4'h0, nib} - 8'd10);
                end else begin
                    digits.push_back(8'h61 + {4'h0, nib} - 8'd10);
                end
                rest = rest >> 4;
            end while (rest != 64'd0);
            if (item.operation == n2a_pkg::OP_PTR) begin
                pending_chars.push_back(n2a_pkg::t_out'{8'h30, 1'b0});
                pending_chars.push_back(n2a_pkg::t_out'{8'h78, 1'b0});
            end
        end
        for (n = digits.size() - 1; n >= 0; n--) begin
            pending_chars.push_back(n2a_pkg::t_out'{digits[n], n == 0});
        end
    endfunction

    // offer one number, then queue its characters once the beat is taken
    task automatic send_number(input n2a_pkg::t_in item, input logic [159:0] text);
        int top;
        int k;
        while ($urandom_range(99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_beat  <= item;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        if (text != BY_FORMATTER) begin
            top = 19;
            while (text[8*top +: 8] == 8'd0) top--;
            for (k = top; k >= 0; k--) begin
                pending_chars.push_back(n2a_pkg::t_out'{text[8*k +: 8], k == 0});
            end
        end else begin
            predict_chars(item);
        end
    endtask

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_off_req != hold_off_done) begin
            out_ready     <= 1'b0;
            hold_off_done <= hold_off_done + 1;
            hold_left     <= HOLD_OFF_LEN;
        end else begin
            out_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && out_ready) begin
            if (pending_chars.size() == 0) begin
                $display("%0t: unexpected beat, expected none, got char %h last %b",
                         $time, out_beat.character, out_beat.last_char);
                mismatch_count++;
            end else begin
                expected_char = pending_chars.pop_front();
                if (out_beat.character !== expected_char.character) begin
                    $display("%0t: character expected %h got %h",
                             $time, expected_char.character, out_beat.character);
                    mismatch_count++;
                end
                if (out_beat.last_char !== expected_char.last_char) begin
                    $display("%0t: last_char expected %b got %b",
                             $time, expected_char.last_char, out_beat.last_char);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: timeout with %0d characters outstanding",
                     $time, pending_chars.size());
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        n2a_pkg::t_in item;
        logic [63:0]  raw;
        int           row;
        int           mix;
        int           n;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (row = 0; row < N_DIRECTED; row++) begin
            send_number(DIRECTED_ROWS[row].stim, DIRECTED_ROWS[row].text);
        end

        for (mix = 0; mix < 4; mix++) begin
            case (mix)
                0: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                    hold_off_req++;
                end
                1: begin
                    tx_idle_pct  = 52;
                    rx_stall_pct = 0;
                end
                2: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 52;
                end
                default: begin
                    tx_idle_pct  = 21;
                    rx_stall_pct = 21;
                end
            endcase
            for (n = 0; n < ITEMS_PER_MIX; n++) begin
                raw = {$urandom, $urandom};
                case ($urandom_range(3))
                    0: item.value = raw;
                    1: item.value = raw >> $urandom_range(63);
                    2: item.value = 64'($urandom_range(15));
                    default: item.value = ~64'd0 >> $urandom_range(63);
                endcase
                item.operation = 2'($urandom_range(3));
                send_number(item, BY_FORMATTER);
            end
        end
        in_valid <= 1'b0;

        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        while (pending_chars.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
